FILE: rtl/scsu_pkg.sv
package scsu_pkg;

  localparam int unsigned MAX_BYTES = 5;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = 2;

  localparam logic [7:0] SQ0 = 8'h01;
  localparam logic [7:0] SQU = 8'h0E;
  localparam logic [7:0] SCU = 8'h0F;
  localparam logic [7:0] SC0 = 8'h10;
  localparam logic [7:0] UC0 = 8'hE0;
  localparam logic [7:0] UQU = 8'hF0;

  localparam logic [31:0] CTRL_PASS = 32'h0000_2601;
  localparam logic [20:0] CP_MAX = 21'h10FFFF;
  localparam logic [15:0] BOM = 16'hFEFF;
  localparam logic [15:0] UQU_LO = 16'hE000;
  localparam logic [15:0] UQU_HI = 16'hF2FF;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      bad;
  } job_t;

  function automatic logic [15:0] win_base(input logic [3:0] idx);
    logic [15:0] b;
    case (idx)
      4'd0:    b = 16'h0080;
      4'd1:    b = 16'h00C0;
      4'd2:    b = 16'h0400;
      4'd3:    b = 16'h0600;
      4'd4:    b = 16'h0900;
      4'd5:    b = 16'h3040;
      4'd6:    b = 16'h30A0;
      4'd7:    b = 16'hFF00;
      4'd8:    b = 16'h0000;
      4'd9:    b = 16'h0080;
      4'd10:   b = 16'h0100;
      4'd11:   b = 16'h0300;
      4'd12:   b = 16'h2000;
      4'd13:   b = 16'h2080;
      4'd14:   b = 16'h2100;
      4'd15:   b = 16'h3000;
      default: b = 16'h0000;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/scsu_encoder.sv
// Minimal SCSU encoder. Each input beat carries one code point or UTF-16 unit;
// each output beat carries one SCSU byte, with tlast on the final byte of the
// item. An item takes one output beat per byte: 1 to 3 for most characters,
// up to 5 for a supplementary code point sent from single-byte mode. The input
// side takes one item per cycle while the 4-entry job queue has room, so the
// byte-wide output channel sets the sustained rate. A code point above
// 0x10FFFF yields one beat with tuser high and a zero byte, and leaves mode and
// window unchanged. Only the predefined dynamic and static windows are used.
module scsu_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [20:0] char_in, [23:21] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  output logic        out_tuser   // [0] bad_input
);
  import scsu_pkg::*;

  job_t wr_job, rd_job;
  logic push, pop, full, empty;

  assign in_tready = !full;
  assign push = in_tvalid && in_tready;

  scsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .char_in (in_tdata[20:0]),
    .push    (push),
    .job     (wr_job)
  );

  scsu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (full),
    .empty  (empty)
  );

  scsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_job     (rd_job),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/scsu_front.sv
module scsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [20:0]   char_in,
  input  logic          push,
  output scsu_pkg::job_t job
);
  import scsu_pkg::*;

  logic        mode_r, mode_nxt;
  logic [2:0]  win_r, win_nxt;

  logic [15:0] c;
  logic [15:0] hit;
  logic [15:0][6:0] off;
  logic        dyn_hit, st_hit;
  logic [2:0]  dw, sw;
  logic        uqu;
  logic [19:0] v;

  assign c = char_in[15:0];
  assign v = 20'(char_in - 21'h010000);
  assign uqu = (c >= UQU_LO) && (c <= UQU_HI);

  always_comb begin
    logic [16:0] diff;
    for (int i = 0; i < 16; i++) begin
      diff = {1'b0, c} - {1'b0, win_base(4'(i))};
      hit[i] = !diff[16] && (diff[15:7] == '0);
      off[i] = diff[6:0];
    end
  end

  always_comb begin
    dyn_hit = |hit[7:0];
    st_hit = |hit[15:8];
    dw = '0;
    sw = '0;
    for (int i = 7; i >= 0; i--) begin
      if (hit[i]) dw = 3'(i);
      if (hit[i+8]) sw = 3'(i);
    end
  end

  always_comb begin
    job = '0;
    mode_nxt = mode_r;
    win_nxt = win_r;
    if (char_in > CP_MAX) begin
      job.cnt = 3'd1;
      job.bad = 1'b1;
    end else if (char_in[20:16] != '0) begin
      if (!mode_r) begin
        job.bytes = {v[7:0], {6'b110111, v[9:8]}, v[17:10], {6'b110110, v[19:18]}, SCU};
        job.cnt = 3'd5;
      end else begin
        job.bytes[3:0] = {v[7:0], {6'b110111, v[9:8]}, v[17:10], {6'b110110, v[19:18]}};
        job.cnt = 3'd4;
      end
      mode_nxt = 1'b1;
    end else if (!mode_r) begin
      if (c < 16'h0020) begin
        if (!CTRL_PASS[c[4:0]]) begin
          job.bytes[1:0] = {c[7:0], SQ0};
          job.cnt = 3'd2;
        end else begin
          job.bytes[0] = c[7:0];
          job.cnt = 3'd1;
        end
      end else if (c <= 16'h007F) begin
        job.bytes[0] = c[7:0];
        job.cnt = 3'd1;
      end else if (hit[{1'b0, win_r}]) begin
        job.bytes[0] = {1'b1, off[{1'b0, win_r}]};
        job.cnt = 3'd1;
      end else if (dyn_hit) begin
        job.bytes[1:0] = {{1'b1, off[{1'b0, dw}]}, SC0 | {5'd0, dw}};
        job.cnt = 3'd2;
        win_nxt = dw;
      end else if (st_hit) begin
        job.bytes[1:0] = {{1'b0, off[{1'b1, sw}]}, 8'(SQ0 + {5'd0, sw})};
        job.cnt = 3'd2;
      end else if (c == BOM) begin
        job.bytes[2:0] = {BOM[7:0], BOM[15:8], SQU};
        job.cnt = 3'd3;
      end else begin
        if (uqu) begin
          job.bytes[3:0] = {c[7:0], c[15:8], UQU, SCU};
          job.cnt = 3'd4;
        end else begin
          job.bytes[2:0] = {c[7:0], c[15:8], SCU};
          job.cnt = 3'd3;
        end
        mode_nxt = 1'b1;
      end
    end else begin
      if (c <= 16'h007F) begin
        if ((c < 16'h0020) && !CTRL_PASS[c[4:0]]) begin
          job.bytes[2:0] = {c[7:0], SQ0, UC0 | {5'd0, win_r}};
          job.cnt = 3'd3;
        end else begin
          job.bytes[1:0] = {c[7:0], UC0 | {5'd0, win_r}};
          job.cnt = 3'd2;
        end
        mode_nxt = 1'b0;
      end else if (dyn_hit) begin
        job.bytes[1:0] = {{1'b1, off[{1'b0, dw}]}, UC0 | {5'd0, dw}};
        job.cnt = 3'd2;
        win_nxt = dw;
        mode_nxt = 1'b0;
      end else if (uqu) begin
        job.bytes[2:0] = {c[7:0], c[15:8], UQU};
        job.cnt = 3'd3;
      end else begin
        job.bytes[1:0] = {c[7:0], c[15:8]};
        job.cnt = 3'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      win_r <= '0;
    end else if (push) begin
      mode_r <= mode_nxt;
      win_r <= win_nxt;
    end
  end

endmodule

FILE: rtl/scsu_queue.sv
module scsu_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scsu_pkg::job_t wr_job,
  input  logic           pop,
  output scsu_pkg::job_t rd_job,
  output logic           full,
  output logic           empty
);
  import scsu_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rd_job = mem_r[rp_r];

  always_comb begin
    wp_nxt = push ? QAW'(wp_r + 1'b1) : wp_r;
    rp_nxt = pop ? QAW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = (QAW+1)'(cnt_r + 1'b1);
    else if (pop && !push) cnt_nxt = (QAW+1)'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/scsu_back.sv
module scsu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  scsu_pkg::job_t rd_job,
  input  logic           empty,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast,
  output logic           out_tuser
);
  import scsu_pkg::*;

  logic                      vld_r, vld_nxt;
  logic [MAX_BYTES-1:0][7:0] bytes_r, bytes_nxt;
  logic [2:0]                rem_r, rem_nxt;
  logic                      bad_r, bad_nxt;
  logic                      adv, last_byte, need;

  assign adv = vld_r && out_tready;
  assign last_byte = (rem_r == 3'd1);
  assign need = !vld_r || (adv && last_byte);
  assign pop = need && !empty;

  assign out_tvalid = vld_r;
  assign out_tdata = bytes_r[0];
  assign out_tlast = last_byte;
  assign out_tuser = bad_r;

  always_comb begin
    vld_nxt = vld_r;
    bytes_nxt = bytes_r;
    rem_nxt = rem_r;
    bad_nxt = bad_r;
    if (adv && !last_byte) begin
      bytes_nxt = {8'h00, bytes_r[MAX_BYTES-1:1]};
      rem_nxt = 3'(rem_r - 1'b1);
    end else if (need) begin
      vld_nxt = !empty;
      bytes_nxt = rd_job.bytes;
      rem_nxt = rd_job.cnt;
      bad_nxt = rd_job.bad;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    rem_r <= rem_nxt;
    bad_r <= bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
  end

endmodule

FILE: verif/tb.sv
module tb;
  import scsu_pkg::*;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
    logic       bad;
  } scsu_beat_t;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_TAIL = 16;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  scsu_beat_t  expected_beats[$];
  logic [7:0]  enc_bytes[$];
  logic        model_ucs_mode;
  logic [2:0]  model_window;
  logic [15:0] win_origin [0:15] = '{
    16'h0080, 16'h00C0, 16'h0400, 16'h0600, 16'h0900, 16'h3040, 16'h30A0, 16'hFF00,
    16'h0000, 16'h0080, 16'h0100, 16'h0300, 16'h2000, 16'h2080, 16'h2100, 16'h3000
  };

  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;

  scsu_encoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic void push_byte(input int b);
    enc_bytes.push_back(b[7:0]);
  endfunction

  function automatic bit in_window(input int origin, input int c);
    return (c >= origin) && (c <= origin + 'h7F);
  endfunction

  function automatic int find_window(input int c);
    for (int i = 0; i < 16; i++) begin
      if (in_window(win_origin[i], c)) return i;
    end
    return -1;
  endfunction

  function automatic void encode_unit(input int c);
    int w;
    int cur;
    for (int pass = 0; pass < 4; pass++) begin
      if (!model_ucs_mode) begin
        cur = win_origin[model_window];
        if (c < 'h20) begin
          if (!CTRL_PASS[c]) push_byte(SQ0);
          push_byte(c);
          return;
        end
        if (c <= 'h7F) begin
          push_byte(c);
          return;
        end
        if (in_window(cur, c)) begin
          push_byte('h80 + (c - cur));
          return;
        end
        w = find_window(c);
        if (w >= 8) begin
          push_byte(SQ0 + (w - 8));
          push_byte(c - win_origin[w]);
          return;
        end
        if (w >= 0) begin
          push_byte(SC0 + w);
          push_byte('h80 + (c - win_origin[w]));
          model_window = w[2:0];
          return;
        end
        if (c == BOM) begin
          push_byte(SQU);
          push_byte(BOM[15:8]);
          push_byte(BOM[7:0]);
          return;
        end
        push_byte(SCU);
        model_ucs_mode = 1'b1;
      end else begin
        w = find_window(c);
        if (c <= 'h7F) begin
          push_byte(UC0 + model_window);
          model_ucs_mode = 1'b0;
        end else if (w >= 0 && w <= 7) begin
          push_byte(UC0 + w);
          model_window = w[2:0];
          model_ucs_mode = 1'b0;
        end else begin
          if (c >= UQU_LO && c <= UQU_HI) push_byte(UQU);
          push_byte(c >> 8);
          push_byte(c & 'hFF);
          return;
        end
      end
    end
  endfunction

  function automatic void predict_bytes(input logic [20:0] cp);
    scsu_beat_t b;
    int v;
    if (cp > CP_MAX) begin
      b.val = 8'h00;
      b.last = 1'b1;
      b.bad = 1'b1;
      expected_beats.push_back(b);
      return;
    end
    enc_bytes.delete();
    if (cp > 21'h00FFFF) begin
      v = int'(cp) - 'h10000;
      encode_unit('hD800 + (v >> 10));
      encode_unit('hDC00 + (v & 'h3FF));
    end else begin
      encode_unit(int'(cp));
    end
    for (int k = 0; k < enc_bytes.size(); k++) begin
      b.val = enc_bytes[k];
      b.last = (k == enc_bytes.size() - 1);
      b.bad = 1'b0;
      expected_beats.push_back(b);
    end
  endfunction

  task automatic send_cp(input logic [20:0] cp);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {3'b000, cp};
    do @(posedge clk); while (!in_tready);
    predict_bytes(cp);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  function automatic logic [20:0] rand_cp(input int kind);
    case (kind)
      0:       return 21'($urandom_range(0, 'h1F));
      1:       return 21'($urandom_range('h20, 'h7F));
      2:       return 21'(win_origin[$urandom_range(0, 7)] + $urandom_range(0, 'h7F));
      3:       return 21'(win_origin[$urandom_range(8, 15)] + $urandom_range(0, 'h7F));
      4:       return 21'($urandom_range(0, 'hFFFF));
      5:       return 21'($urandom_range(UQU_LO, UQU_HI));
      6:       return 21'($urandom_range('h10000, CP_MAX));
      7:       return 21'($urandom_range('hD800, 'hDFFF));
      8:       return 21'(BOM);
      default: return ($urandom_range(0, 1) != 0) ? 21'($urandom_range(CP_MAX + 1, 'h1FFFFF))
                                                   : 21'($urandom);
    endcase
  endfunction

  task automatic test_controls_ascii();
    send_cp(21'h00);
    send_cp(21'h09);
    send_cp(21'h0A);
    send_cp(21'h0D);
    send_cp(21'h01);
    send_cp(21'h1F);
    send_cp(21'h41);
    send_cp(21'h7F);
  endtask

  task automatic test_windows();
    send_cp(21'h0080);
    send_cp(21'h0120);
    send_cp(21'h0410);
    send_cp(21'h3005);
    send_cp(21'h2010);
    send_cp(21'hFF7F);
  endtask

  task automatic test_unicode_mode();
    send_cp(21'h00FEFF);
    send_cp(21'h004E00);
    send_cp(21'h004E01);
    send_cp(21'h00E123);
    send_cp(21'h000041);
    send_cp(21'h004E00);
    send_cp(21'h0030A5);
    send_cp(21'h01F600);
    send_cp(21'h00D83D);
    send_cp(21'h00DE00);
  endtask

  task automatic test_bad_input();
    send_cp(21'h110000);
    send_cp(21'h1FFFFF);
  endtask

  task automatic test_random_text(input int n_items);
    int sent;
    int r;
    int kind;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 12) kind = 0;
      else if (r < 35) kind = 1;
      else if (r < 55) kind = 2;
      else if (r < 63) kind = 3;
      else if (r < 75) kind = 4;
      else if (r < 81) kind = 5;
      else if (r < 89) kind = 6;
      else if (r < 93) kind = 7;
      else if (r < 95) kind = 8;
      else kind = 9;
      run_len = $urandom_range(1, 8);
      for (int j = 0; j < run_len && sent < n_items; j++) begin
        send_cp(rand_cp(kind));
        sent++;
      end
    end
  endtask

  task automatic test_drain_pause();
    wait_drained();
    send_cp(21'h004E00);
    send_cp(21'h000061);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    model_ucs_mode = 1'b0;
    model_window = 3'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_controls_ascii();
    test_windows();
    test_unicode_mode();
    test_bad_input();

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_random_text(180);
    test_drain_pause();
    test_random_text(170);

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_text(50);

    wait_drained();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin : check_beats
    scsu_beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: out_byte %02h last %0b bad_input %0b",
               out_tdata, out_tlast, out_tuser);
        mismatches++;
      end else begin
        e = expected_beats.pop_front();
        if (out_tdata !== e.val) begin
          $error("out_byte expected %02h actual %02h", e.val, out_tdata);
          mismatches++;
        end
        if (out_tlast !== e.last) begin
          $error("last expected %0b actual %0b", e.last, out_tlast);
          mismatches++;
        end
        if (out_tuser !== e.bad) begin
          $error("bad_input expected %0b actual %0b", e.bad, out_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
